// ----- rtl/cec_pkg.sv -----
// Shared types and constants for the classifier event confirmation block.
`timescale 1ns / 1ps

package cec_pkg;

  // Default widths of a probability and of a streak counter.
  localparam int PROB_BITS_DEF = 16;
  localparam int RUN_BITS_DEF  = 8;

  // Configuration port layout.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = 2'd2;

  localparam int CONFIRM_BITS   = 8;
  localparam int TOLERANCE_BITS = 7;

  // Reset values of the configuration registers.
  localparam logic [31:0]               THRESHOLD_RST = 32'd32768;
  localparam logic [CONFIRM_BITS-1:0]   CONFIRM_RST   = 8'd2;
  localparam logic [TOLERANCE_BITS-1:0] TOLERANCE_RST = 7'd5;

  // Class codes; the event code uses the same encoding with zero as none.
  localparam logic [1:0] CLS_NOISE    = 2'd0;
  localparam logic [1:0] CLS_KNOCK    = 2'd1;
  localparam logic [1:0] CLS_DOORBELL = 2'd2;
  localparam logic [1:0] CLS_NONE     = 2'd3;
  localparam logic [1:0] EV_NONE      = 2'd0;

  // How the back end has to treat a classified request.
  typedef enum logic [1:0] {
    KIND_SILENT = 2'd0,
    KIND_NOISE  = 2'd1,
    KIND_DOUBT  = 2'd2,
    KIND_SURE   = 2'd3
  } kind_t;

  // Control part of a queued request.
  typedef struct packed {
    kind_t      kind;
    logic [1:0] cls;
  } tag_t;

  localparam int TAG_BITS = $bits(tag_t);

endpackage

// ----- rtl/classifier_event_confirmation.sv -----
// Top level of the classifier event confirmation block.
// Usage: one request on the req channel is one classifier verdict (silence
// flag and three class probabilities). Each request gives exactly one result
// on the rsp channel: the event code, the winning probability and the three
// probabilities passed on (for silence: all-ones noise, all else zero). Both channels use valid and stall.
// The request passes through the queue and then the result register, where
// rsp_valid rises. Throughput is one request per cycle while rsp_stall is low,
// set by the streak update in the back end.
// A two-entry queue sits between the classifying front end and the
// back end, so a stalled result lets two more requests in before req_stall
// rises; req_stall is high exactly while that queue is full.
// Configuration is written through cfg_write, cfg_index and cfg_data: index 0
// the threshold, 1 the confirmation count, 2 the noise streak limit; other
// indexes are ignored. The user must write only while no request is in flight; the block does not enforce it.
// Synchronous reset empties the queue and the result register, clears the
// streaks, forgets the held class and restores the register defaults.
`timescale 1ns / 1ps

module classifier_event_confirmation #(
  parameter int PROB_BITS = cec_pkg::PROB_BITS_DEF,
  parameter int RUN_BITS  = cec_pkg::RUN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [cec_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [PROB_BITS-1:0]              cfg_data,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              silent,
  input  logic [PROB_BITS-1:0]              prob_noise,
  input  logic [PROB_BITS-1:0]              prob_knock,
  input  logic [PROB_BITS-1:0]              prob_doorbell,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [1:0]                        event_res,
  output logic [PROB_BITS-1:0]              confidence,
  output logic [PROB_BITS-1:0]              out_noise,
  output logic [PROB_BITS-1:0]              out_knock,
  output logic [PROB_BITS-1:0]              out_doorbell
);
  import cec_pkg::*;

  localparam int QW = TAG_BITS + 4 * PROB_BITS;

  logic [PROB_BITS-1:0]      threshold;
  logic [CONFIRM_BITS-1:0]   confirm_needed;
  logic [TOLERANCE_BITS-1:0] noise_allow;

  tag_t                 front_tag;
  logic [4*PROB_BITS-1:0] front_payload;
  logic                 q_full;
  logic                 q_avail;
  logic                 q_pop;
  logic [QW-1:0]        q_out;
  tag_t                 back_tag;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= THRESHOLD_RST[PROB_BITS-1:0];
      confirm_needed <= CONFIRM_RST;
      noise_allow    <= TOLERANCE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: threshold      <= cfg_data;
        REG_CONFIRM:   confirm_needed <= cfg_data[CONFIRM_BITS-1:0];
        REG_TOLERANCE: noise_allow    <= cfg_data[TOLERANCE_BITS-1:0];
        default:       threshold      <= threshold;
      endcase
    end
  end

  assign req_stall = q_full;

  cec_front #(
    .PROB_BITS(PROB_BITS)
  ) u_front (
    .silent        (silent),
    .prob_noise    (prob_noise),
    .prob_knock    (prob_knock),
    .prob_doorbell (prob_doorbell),
    .threshold     (threshold),
    .tag           (front_tag),
    .payload       (front_payload)
  );

  cec_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid),
    .push_data ({front_tag, front_payload}),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_out)
  );

  assign back_tag = q_out[QW-1:4*PROB_BITS];

  cec_back #(
    .PROB_BITS(PROB_BITS),
    .RUN_BITS (RUN_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .avail           (q_avail),
    .tag             (back_tag),
    .payload         (q_out[4*PROB_BITS-1:0]),
    .pop             (q_pop),
    .confirm_needed  (confirm_needed),
    .noise_allow     (noise_allow),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .event_res       (event_res),
    .confidence      (confidence),
    .out_noise       (out_noise),
    .out_knock       (out_knock),
    .out_doorbell    (out_doorbell)
  );

`ifndef ASSERT_OFF
  // A reported event never comes from a verdict that noise won or tied.
  a_event_beats_noise: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && event_res != EV_NONE) |-> (confidence > out_noise))
    else $error("event reported although noise was not beaten");

  // A knock event carries the knock probability as its confidence.
  a_knock_wins: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && event_res == CLS_KNOCK) |->
      (confidence == out_knock && out_knock >= out_doorbell))
    else $error("knock event does not match the winning class");

  // A doorbell event strictly beats knock, since ties go to knock.
  a_doorbell_wins: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && event_res == CLS_DOORBELL) |->
      (confidence == out_doorbell && out_doorbell > out_knock))
    else $error("doorbell event does not match the winning class");

  // The queue is empty after reset, so requests are taken at once.
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> !req_stall)
    else $error("request stalled right after reset");
`endif

endmodule

// ----- rtl/cec_front.sv -----
// Front end: picks the winning class and sorts the request into a kind.
`timescale 1ns / 1ps

module cec_front #(
  parameter int PROB_BITS = cec_pkg::PROB_BITS_DEF
) (
  input  logic                   silent,
  input  logic [PROB_BITS-1:0]   prob_noise,
  input  logic [PROB_BITS-1:0]   prob_knock,
  input  logic [PROB_BITS-1:0]   prob_doorbell,
  input  logic [PROB_BITS-1:0]   threshold,
  output cec_pkg::tag_t          tag,
  output logic [4*PROB_BITS-1:0] payload
);
  import cec_pkg::*;

  logic [1:0]           win;
  logic [PROB_BITS-1:0] win_prob;

  // Winner search; a tie keeps the lower class.
  always_comb begin
    win      = CLS_NOISE;
    win_prob = prob_noise;
    if (prob_knock > win_prob) begin
      win      = CLS_KNOCK;
      win_prob = prob_knock;
    end
    if (prob_doorbell > win_prob) begin
      win      = CLS_DOORBELL;
      win_prob = prob_doorbell;
    end
  end

  // Kind of request and the probabilities that go out with it.
  always_comb begin
    tag.cls = win;
    if (silent) begin
      tag.kind = KIND_SILENT;
      payload  = {{PROB_BITS{1'b0}}, {PROB_BITS{1'b1}}, {PROB_BITS{1'b0}},
                  {PROB_BITS{1'b0}}};
    end else begin
      if (win == CLS_NOISE) begin
        tag.kind = KIND_NOISE;
      end else if (win_prob < threshold) begin
        tag.kind = KIND_DOUBT;
      end else begin
        tag.kind = KIND_SURE;
      end
      payload = {win_prob, prob_noise, prob_knock, prob_doorbell};
    end
  end

endmodule

// ----- rtl/cec_queue.sv -----
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps

module cec_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == 2'd2);
  assign avail    = (count != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;
  assign pop_data = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/cec_back.sv -----
// Back end: streak counters, held class and the result register.
`timescale 1ns / 1ps

module cec_back #(
  parameter int PROB_BITS = cec_pkg::PROB_BITS_DEF,
  parameter int RUN_BITS  = cec_pkg::RUN_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                avail,
  input  cec_pkg::tag_t                       tag,
  input  logic [4*PROB_BITS-1:0]              payload,
  output logic                                pop,
  input  logic [cec_pkg::CONFIRM_BITS-1:0]    confirm_needed,
  input  logic [cec_pkg::TOLERANCE_BITS-1:0]  noise_allow,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [1:0]                          event_res,
  output logic [PROB_BITS-1:0]                confidence,
  output logic [PROB_BITS-1:0]                out_noise,
  output logic [PROB_BITS-1:0]                out_knock,
  output logic [PROB_BITS-1:0]                out_doorbell
);
  import cec_pkg::*;

  // Compare width that holds both the counters and the limits.
  localparam int CW = (RUN_BITS > CONFIRM_BITS) ? RUN_BITS : CONFIRM_BITS;

  logic [1:0]          held_class, held_class_next;
  logic [RUN_BITS-1:0] confirm_run, confirm_run_next;
  logic [RUN_BITS-1:0] noise_run, noise_run_next;
  logic [RUN_BITS-1:0] doubt_run, doubt_run_next;
  logic [RUN_BITS-1:0] noise_inc, doubt_inc, confirm_inc;
  logic [CW-1:0]       noise_limit, doubt_limit;
  logic [1:0]          event_next;

  // Saturating increments of the streak counters.
  assign noise_inc   = (&noise_run)   ? noise_run   : noise_run + 1'b1;
  assign doubt_inc   = (&doubt_run)   ? doubt_run   : doubt_run + 1'b1;
  assign confirm_inc = (&confirm_run) ? confirm_run : confirm_run + 1'b1;

  assign noise_limit = CW'(noise_allow);
  assign doubt_limit = CW'({noise_allow, 1'b0});

  // The result register frees up when it is empty or being taken.
  assign pop = avail && (!rsp_valid || !rsp_stall);

  // Streak update for one request.
  always_comb begin
    held_class_next  = held_class;
    confirm_run_next = confirm_run;
    noise_run_next   = noise_run;
    doubt_run_next   = doubt_run;
    event_next       = EV_NONE;
    unique case (tag.kind)
      KIND_SILENT, KIND_NOISE: begin
        noise_run_next = noise_inc;
        if (CW'(noise_inc) > noise_limit) begin
          held_class_next  = CLS_NOISE;
          confirm_run_next = '0;
        end
        if (tag.kind == KIND_SILENT) begin
          doubt_run_next = '0;
        end
      end
      KIND_DOUBT: begin
        if (CW'(doubt_inc) > doubt_limit) begin
          held_class_next  = CLS_NONE;
          confirm_run_next = '0;
          doubt_run_next   = '0;
        end else begin
          doubt_run_next = doubt_inc;
        end
      end
      KIND_SURE: begin
        noise_run_next = '0;
        doubt_run_next = '0;
        if (tag.cls == held_class) begin
          confirm_run_next = confirm_inc;
        end else begin
          held_class_next  = tag.cls;
          confirm_run_next = RUN_BITS'(1);
        end
        if (CW'(confirm_run_next) >= CW'(confirm_needed)) begin
          event_next = tag.cls;
        end
      end
    endcase
  end

  // State and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_class  <= CLS_NONE;
      confirm_run <= '0;
      noise_run   <= '0;
      doubt_run   <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (pop) begin
        held_class  <= held_class_next;
        confirm_run <= confirm_run_next;
        noise_run   <= noise_run_next;
        doubt_run   <= doubt_run_next;
        rsp_valid   <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      event_res    <= event_next;
      confidence   <= payload[4*PROB_BITS-1:3*PROB_BITS];
      out_noise    <= payload[3*PROB_BITS-1:2*PROB_BITS];
      out_knock    <= payload[2*PROB_BITS-1:PROB_BITS];
      out_doorbell <= payload[PROB_BITS-1:0];
    end
  end

endmodule
